// ===== rtl/core/sqvt_pkg.sv =====
// ----------------------------------------------------------------------------
// sqvt_pkg: shared types and constants for the sprite quad vertex transform
// Holds the sizes, the quarter-wave sine table, a saturation helper and the
// command and status records between the controller and the datapath.
// ----------------------------------------------------------------------------
package sqvt_pkg;

  // Sizing
  localparam int MAX_SPRITES     = 1024;
  localparam int SINE_TABLE_BITS = 10;
  localparam int SINE_STEPS      = 2 ** SINE_TABLE_BITS;
  localparam int QUARTER         = SINE_STEPS / 4;
  localparam int QIDX_W          = SINE_TABLE_BITS - 2;
  localparam int LIMIT_CAP       = (MAX_SPRITES < 2047) ? MAX_SPRITES : 2047;

  localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;

  // Field widths
  localparam int CFG_W       = 13;
  localparam int CFG_IDX_W   = 3;
  localparam int LIMIT_W     = 11;
  localparam int COORD_W     = 16;
  localparam int ANGLE_W     = 16;
  localparam int COLOR_W     = 32;
  localparam int SLOT_W      = 12;
  localparam int CORNER_W    = 2;
  localparam int SPRITE_NUM_W = SLOT_W - CORNER_W;
  localparam int QS_W        = 15;
  localparam int TRIG_W      = 16;
  localparam int PROD_W      = 32;
  localparam int CENTER_W    = 18;
  localparam int TEX_W       = 17;
  localparam int DIV_N_W     = 37;
  localparam int DIV_D_W     = 17;
  localparam int DIV_Q_W     = 17;
  localparam int QUOT_W      = DIV_Q_W + 2;
  localparam int WIDE_W      = QUOT_W + 1;

  // Reset values of the configuration registers
  localparam logic [CFG_W-1:0]   SCREEN_W_RST = 13'd1280;
  localparam logic [CFG_W-1:0]   SCREEN_H_RST = 13'd720;
  localparam logic [CFG_W-1:0]   TEX_W_RST    = 13'd256;
  localparam logic [CFG_W-1:0]   TEX_H_RST    = 13'd256;
  localparam logic [LIMIT_W-1:0] LIMIT_RST    = 11'd1024;
  localparam logic [LIMIT_W-1:0] LIMIT_MAX    = LIMIT_W'(LIMIT_CAP);

  // Operation codes
  localparam logic OP_BEGIN = 1'b0;
  localparam logic OP_DRAW  = 1'b1;

  localparam logic [CORNER_W-1:0] CORNER_LAST = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_W     = 3'd0,
    CFG_SCREEN_H     = 3'd1,
    CFG_TEXTURE_W    = 3'd2,
    CFG_TEXTURE_H    = 3'd3,
    CFG_SPRITE_LIMIT = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    FLD_X = 2'd0,
    FLD_Y = 2'd1,
    FLD_U = 2'd2,
    FLD_V = 2'd3
  } field_t;

  typedef struct packed {
    logic                       op;
    logic signed [COORD_W-1:0]  dest_x;
    logic signed [COORD_W-1:0]  dest_y;
    logic signed [COORD_W-1:0]  dest_w;
    logic signed [COORD_W-1:0]  dest_h;
    logic signed [COORD_W-1:0]  src_x;
    logic signed [COORD_W-1:0]  src_y;
    logic signed [COORD_W-1:0]  src_w;
    logic signed [COORD_W-1:0]  src_h;
    logic [ANGLE_W-1:0]         rotation;
    logic [COLOR_W-1:0]         color;
  } sprite_t;

  typedef struct packed {
    logic [SLOT_W-1:0]          vertex_slot;
    logic signed [COORD_W-1:0]  ndc_x;
    logic signed [COORD_W-1:0]  ndc_y;
    logic signed [COORD_W-1:0]  tex_u;
    logic signed [COORD_W-1:0]  tex_v;
    logic [COLOR_W-1:0]         vertex_color;
    logic                       last;
  } vertex_t;

  // Controller to datapath
  typedef struct packed {
    logic                clear_count;
    logic                capture;
    logic                lookup;
    logic                mul_en;
    logic [1:0]          mul_idx;
    logic                pos_en;
    logic [CORNER_W-1:0] corner;
    logic                div_start;
    field_t              field_sel;
    logic                store_field;
    logic                load_out;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic drop;
    logic div_busy;
    logic div_done;
    logic out_free;
  } dp_status_t;

  // Quarter-wave sine entry, Q1.14, Taylor series through x^15
  function automatic logic [QS_W-1:0] quarter_sine(int unsigned r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    longint      v;
    x = ((64'(r) * TWO_PI_Q30) + (64'd1 << (SINE_TABLE_BITS - 1))) >> SINE_TABLE_BITS;
    x2 = (x * x) >> 30;
    // x^3/3! through x^15/15!, alternating signs
    term = ((x * x2) >> 30) / 64'd6;
    sum  = longint'(x) - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd210;
    sum  = sum - longint'(term);
    v = (sum + 64'sd32768) >>> 16;
    if (v < 0)     v = 0;
    if (v > 16384) v = 16384;
    return v[QS_W-1:0];
  endfunction

  typedef logic [QS_W-1:0] sine_rom_t [QUARTER];

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    int        i;
    for (i = 0; i < QUARTER; i++) rom[i] = quarter_sine(i);
    return rom;
  endfunction

  localparam sine_rom_t       SINE_ROM  = build_sine_rom();
  localparam logic [QS_W-1:0] SINE_PEAK = quarter_sine(QUARTER);

  // Full-wave sine from the quarter table, Q1.14
  function automatic logic signed [TRIG_W-1:0] sine_at(logic [SINE_TABLE_BITS-1:0] k);
    logic [QIDX_W-1:0] r;
    logic [QIDX_W-1:0] idx;
    logic [QS_W-1:0]   mag;
    r   = k[QIDX_W-1:0];
    idx = k[QIDX_W] ? (QIDX_W'(0) - r) : r;
    mag = (k[QIDX_W] && (r == '0)) ? SINE_PEAK : SINE_ROM[idx];
    return k[QIDX_W+1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  function automatic logic signed [COORD_W-1:0] sat16(logic signed [WIDE_W-1:0] v);
    if (v > $signed(WIDE_W'(32767)))       return 16'sh7FFF;
    else if (v < -$signed(WIDE_W'(32768))) return 16'sh8000;
    else                                   return v[COORD_W-1:0];
  endfunction

endpackage

// ===== rtl/core/sqvt_sprite_if.sv =====
// ----------------------------------------------------------------------------
// sqvt_sprite_if: sprite command channel
// Valid/ready channel that carries one begin or draw command per transfer.
// ----------------------------------------------------------------------------
interface sqvt_sprite_if;
  logic                               valid;
  logic                               ready;
  logic                               op;
  logic signed [sqvt_pkg::COORD_W-1:0] dest_x;
  logic signed [sqvt_pkg::COORD_W-1:0] dest_y;
  logic signed [sqvt_pkg::COORD_W-1:0] dest_w;
  logic signed [sqvt_pkg::COORD_W-1:0] dest_h;
  logic signed [sqvt_pkg::COORD_W-1:0] src_x;
  logic signed [sqvt_pkg::COORD_W-1:0] src_y;
  logic signed [sqvt_pkg::COORD_W-1:0] src_w;
  logic signed [sqvt_pkg::COORD_W-1:0] src_h;
  logic [sqvt_pkg::ANGLE_W-1:0]        rotation;
  logic [sqvt_pkg::COLOR_W-1:0]        color;

  modport source (
    output valid, op, dest_x, dest_y, dest_w, dest_h,
           src_x, src_y, src_w, src_h, rotation, color,
    input  ready
  );
  modport sink (
    input  valid, op, dest_x, dest_y, dest_w, dest_h,
           src_x, src_y, src_w, src_h, rotation, color,
    output ready
  );
endinterface

// ===== rtl/core/sqvt_vertex_if.sv =====
// ----------------------------------------------------------------------------
// sqvt_vertex_if: vertex result channel
// Valid/ready channel that carries one transformed corner vertex per transfer.
// ----------------------------------------------------------------------------
interface sqvt_vertex_if;
  logic                               valid;
  logic                               ready;
  logic [sqvt_pkg::SLOT_W-1:0]         vertex_slot;
  logic signed [sqvt_pkg::COORD_W-1:0] ndc_x;
  logic signed [sqvt_pkg::COORD_W-1:0] ndc_y;
  logic signed [sqvt_pkg::COORD_W-1:0] tex_u;
  logic signed [sqvt_pkg::COORD_W-1:0] tex_v;
  logic [sqvt_pkg::COLOR_W-1:0]        vertex_color;
  logic                               last;

  modport source (
    output valid, vertex_slot, ndc_x, ndc_y, tex_u, tex_v, vertex_color, last,
    input  ready
  );
  modport sink (
    input  valid, vertex_slot, ndc_x, ndc_y, tex_u, tex_v, vertex_color, last,
    output ready
  );
endinterface

// ===== rtl/core/sqvt_div.sv =====
// ----------------------------------------------------------------------------
// sqvt_div: sequential floor divider
// Signed dividend over positive divisor, one quotient bit per cycle. Large
// quotients are flagged early and returned clamped beyond the output range.
// ----------------------------------------------------------------------------
module sqvt_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [sqvt_pkg::DIV_N_W-1:0] dividend,
  input  logic [sqvt_pkg::DIV_D_W-1:0]        divisor,
  output logic                                busy,
  output logic                                done,
  output logic signed [sqvt_pkg::QUOT_W-1:0]  quotient
);
  import sqvt_pkg::*;

  localparam int CNT_W = $clog2(DIV_Q_W);
  localparam int HI_W  = DIV_N_W - 1 - DIV_Q_W;

  logic                     prep;
  logic [CNT_W-1:0]         cnt;
  logic                     neg;
  logic                     ovf;
  logic signed [DIV_N_W-1:0] dvd;
  logic [DIV_D_W-1:0]       dvs;
  logic [DIV_D_W-1:0]       rem;
  logic [DIV_Q_W-1:0]       low;
  logic [DIV_Q_W-1:0]       quot;

  logic [DIV_N_W-2:0]       mag;
  logic [HI_W-1:0]          hi;
  logic [DIV_D_W:0]         trial;
  logic                     qbit;
  logic [DIV_Q_W:0]         qmag;

  // floor(a/b) for negative a is ~((~a)/b)
  assign mag   = dvd[DIV_N_W-1] ? ~dvd[DIV_N_W-2:0] : dvd[DIV_N_W-2:0];
  assign hi    = mag[DIV_N_W-2:DIV_Q_W];
  assign trial = {rem, low[DIV_Q_W-1]};
  assign qbit  = (trial >= {1'b0, dvs});

  // Control and shift registers
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      prep <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        prep <= 1'b1;
        dvd  <= dividend;
        dvs  <= divisor;
      end else if (prep) begin
        prep <= 1'b0;
        neg  <= dvd[DIV_N_W-1];
        ovf  <= (hi >= HI_W'(dvs));
        rem  <= hi[DIV_D_W-1:0];
        low  <= mag[DIV_Q_W-1:0];
        cnt  <= '0;
      end else if (busy) begin
        rem  <= qbit ? DIV_D_W'(trial - {1'b0, dvs}) : trial[DIV_D_W-1:0];
        quot <= {quot[DIV_Q_W-2:0], qbit};
        low  <= {low[DIV_Q_W-2:0], 1'b0};
        cnt  <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_Q_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Signed result
  assign qmag     = ovf ? {1'b1, {DIV_Q_W{1'b0}}} : {1'b0, quot};
  assign quotient = neg ? ~$signed({1'b0, qmag}) : $signed({1'b0, qmag});

endmodule

// ===== rtl/core/sqvt_dp.sv =====
// ----------------------------------------------------------------------------
// sqvt_dp: sprite quad datapath
// Configuration registers, sprite counter, sine lookup, shared multiplier,
// corner position, divider operand select and the vertex output register.
// ----------------------------------------------------------------------------
module sqvt_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [sqvt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sqvt_pkg::CFG_W-1:0]       cfg_data,
  input  sqvt_pkg::sprite_t                in_data,
  input  sqvt_pkg::ctrl_cmd_t              cmd,
  output sqvt_pkg::dp_status_t             status,
  output sqvt_pkg::vertex_t                out_data,
  output logic                             out_valid,
  input  logic                             out_ready
);
  import sqvt_pkg::*;

  logic [CFG_W-1:0]          scr_w;
  logic [CFG_W-1:0]          scr_h;
  logic [CFG_W-1:0]          tex_w;
  logic [CFG_W-1:0]          tex_h;
  logic [LIMIT_W-1:0]        limit;
  logic [LIMIT_W-1:0]        count;
  logic [SPRITE_NUM_W-1:0]   base;
  sprite_t                   item;

  logic signed [TRIG_W-1:0]   sn;
  logic signed [TRIG_W-1:0]   cs;
  logic signed [CENTER_W-1:0] cx;
  logic signed [CENTER_W-1:0] cy;
  logic signed [PROD_W-1:0]   prod [4];
  logic signed [DIV_N_W-1:0]  px;
  logic signed [DIV_N_W-1:0]  py;
  logic signed [TEX_W-1:0]    tu;
  logic signed [TEX_W-1:0]    tv;
  logic signed [COORD_W-1:0]  res_x;
  logic signed [COORD_W-1:0]  res_y;
  logic signed [COORD_W-1:0]  res_u;
  logic signed [COORD_W-1:0]  res_v;

  logic [LIMIT_W-1:0]         eff_limit;
  logic [CFG_W-1:0]           w_eff;
  logic [CFG_W-1:0]           h_eff;
  logic [CFG_W-1:0]           tw_eff;
  logic [CFG_W-1:0]           th_eff;
  logic [ANGLE_W:0]           angle_sum;
  logic [SINE_TABLE_BITS-1:0] k_sin;
  logic [SINE_TABLE_BITS-1:0] k_cos;
  logic signed [TRIG_W-1:0]   mul_a;
  logic signed [COORD_W-1:0]  mul_b;
  logic signed [DIV_N_W-1:0]  cx_ext;
  logic signed [DIV_N_W-1:0]  cy_ext;
  logic signed [DIV_N_W-1:0]  pa;
  logic signed [DIV_N_W-1:0]  pb;
  logic signed [DIV_N_W-1:0]  pc;
  logic signed [DIV_N_W-1:0]  pd;
  logic signed [DIV_N_W-1:0]  div_n;
  logic [DIV_D_W-1:0]         div_d;
  logic                       div_busy;
  logic                       div_done;
  logic signed [QUOT_W-1:0]   quot;
  logic signed [WIDE_W-1:0]   q_ext;

  // Effective sizes and limit
  assign eff_limit = (limit > LIMIT_MAX) ? LIMIT_MAX : limit;
  assign w_eff     = (scr_w == '0) ? CFG_W'(1) : scr_w;
  assign h_eff     = (scr_h == '0) ? CFG_W'(1) : scr_h;
  assign tw_eff    = (tex_w == '0) ? CFG_W'(1) : tex_w;
  assign th_eff    = (tex_h == '0) ? CFG_W'(1) : tex_h;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scr_w <= SCREEN_W_RST;
      scr_h <= SCREEN_H_RST;
      tex_w <= TEX_W_RST;
      tex_h <= TEX_H_RST;
      limit <= LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCREEN_W:     scr_w <= cfg_data;
        CFG_SCREEN_H:     scr_h <= cfg_data;
        CFG_TEXTURE_W:    tex_w <= cfg_data;
        CFG_TEXTURE_H:    tex_h <= cfg_data;
        CFG_SPRITE_LIMIT: limit <= cfg_data[LIMIT_W-1:0];
        default:          ;
      endcase
    end
  end

  // Sprite counter
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear_count) begin
      count <= '0;
    end else if (cmd.capture) begin
      count <= count + 1'b1;
    end
  end

  // Captured command
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= in_data;
      base <= count[SPRITE_NUM_W-1:0];
    end
  end

  // Sine and cosine lookup, rectangle centre
  assign angle_sum = {1'b0, item.rotation} + (ANGLE_W+1)'(1 << (15 - SINE_TABLE_BITS));
  assign k_sin     = angle_sum[ANGLE_W-1:ANGLE_W-SINE_TABLE_BITS];
  assign k_cos     = k_sin + SINE_TABLE_BITS'(QUARTER);

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      sn <= sine_at(k_sin);
      cs <= sine_at(k_cos);
      cx <= $signed({item.dest_x[COORD_W-1], item.dest_x, 1'b0})
            + CENTER_W'(item.dest_w);
      cy <= $signed({item.dest_y[COORD_W-1], item.dest_y, 1'b0})
            + CENTER_W'(item.dest_h);
    end
  end

  // Shared multiplier: cos*w, sin*h, sin*w, cos*h
  always_comb begin
    unique case (cmd.mul_idx)
      2'd0: begin mul_a = cs; mul_b = item.dest_w; end
      2'd1: begin mul_a = sn; mul_b = item.dest_h; end
      2'd2: begin mul_a = sn; mul_b = item.dest_w; end
      default: begin mul_a = cs; mul_b = item.dest_h; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) prod[cmd.mul_idx] <= mul_a * mul_b;
  end

  // Corner position and texture coordinate
  assign cx_ext = DIV_N_W'(cx);
  assign cy_ext = DIV_N_W'(cy);
  assign pa     = DIV_N_W'(prod[0]);
  assign pb     = DIV_N_W'(prod[1]);
  assign pc     = DIV_N_W'(prod[2]);
  assign pd     = DIV_N_W'(prod[3]);

  always_ff @(posedge clk) begin
    if (cmd.pos_en) begin
      px <= (cx_ext <<< 14) + (cmd.corner[0] ? pa : -pa) - (cmd.corner[1] ? pb : -pb);
      py <= (cy_ext <<< 14) + (cmd.corner[0] ? pc : -pc) + (cmd.corner[1] ? pd : -pd);
      tu <= cmd.corner[0] ? TEX_W'(item.src_x) + TEX_W'(item.src_w) : TEX_W'(item.src_x);
      tv <= cmd.corner[1] ? TEX_W'(item.src_y) + TEX_W'(item.src_h) : TEX_W'(item.src_y);
    end
  end

  // Divider operands
  always_comb begin
    unique case (cmd.field_sel)
      FLD_X: begin
        div_n = px + $signed({21'b0, w_eff, 3'b0});
        div_d = {w_eff, 4'b0};
      end
      FLD_Y: begin
        div_n = py + $signed({21'b0, h_eff, 3'b0});
        div_d = {h_eff, 4'b0};
      end
      FLD_U: begin
        div_n = (DIV_N_W'(tu) <<< 9) + $signed({24'b0, tw_eff});
        div_d = {3'b0, tw_eff, 1'b0};
      end
      default: begin
        div_n = (DIV_N_W'(tv) <<< 9) + $signed({24'b0, th_eff});
        div_d = {3'b0, th_eff, 1'b0};
      end
    endcase
  end

  sqvt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quot)
  );

  // Offset the NDC quotients and saturate each quotient
  assign q_ext = WIDE_W'(quot);

  always_ff @(posedge clk) begin
    if (cmd.store_field) begin
      unique case (cmd.field_sel)
        FLD_X:   res_x <= sat16(q_ext - WIDE_W'(16384));
        FLD_Y:   res_y <= sat16(WIDE_W'(16384) - q_ext);
        FLD_U:   res_u <= sat16(q_ext);
        default: res_v <= sat16(q_ext);
      endcase
    end
  end

  // Vertex output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.vertex_slot  <= {base, cmd.corner};
      out_data.ndc_x        <= res_x;
      out_data.ndc_y        <= res_y;
      out_data.tex_u        <= res_u;
      out_data.tex_v        <= res_v;
      out_data.vertex_color <= item.color;
      out_data.last         <= (cmd.corner == CORNER_LAST);
    end
  end

  // Status to controller
  assign status.drop     = (count >= eff_limit);
  assign status.div_busy = div_busy;
  assign status.div_done = div_done;
  assign status.out_free = !out_valid || out_ready;

endmodule

// ===== rtl/core/sqvt_ctrl.sv =====
// ----------------------------------------------------------------------------
// sqvt_ctrl: sprite quad controller
// Sequences lookup, four products, and per corner the position and four
// divisions, then hands each vertex to the output register.
// ----------------------------------------------------------------------------
module sqvt_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_op,
  output logic                  in_ready,
  input  sqvt_pkg::dp_status_t  status,
  output sqvt_pkg::ctrl_cmd_t   cmd
);
  import sqvt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_MUL,
    S_POS,
    S_DIV_LOAD,
    S_DIV_WAIT,
    S_EMIT
  } state_t;

  state_t              state;
  logic [1:0]          mul_idx;
  field_t              sel;
  logic [CORNER_W-1:0] corner;
  logic                accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Commands decoded from state
  always_comb begin
    cmd             = '0;
    cmd.mul_idx     = mul_idx;
    cmd.corner      = corner;
    cmd.field_sel   = sel;
    cmd.clear_count = accept && (in_op == OP_BEGIN);
    cmd.capture     = accept && (in_op == OP_DRAW) && !status.drop;
    cmd.lookup      = (state == S_LOOKUP);
    cmd.mul_en      = (state == S_MUL);
    cmd.pos_en      = (state == S_POS);
    cmd.div_start   = (state == S_DIV_LOAD);
    cmd.store_field = (state == S_DIV_WAIT) && status.div_done;
    cmd.load_out    = (state == S_EMIT) && status.out_free;
  end

  // State and step counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      mul_idx <= '0;
      sel     <= FLD_X;
      corner  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.capture) state <= S_LOOKUP;
        end
        S_LOOKUP: begin
          mul_idx <= '0;
          state   <= S_MUL;
        end
        S_MUL: begin
          mul_idx <= mul_idx + 1'b1;
          if (mul_idx == 2'd3) begin
            corner <= '0;
            state  <= S_POS;
          end
        end
        S_POS: begin
          sel   <= FLD_X;
          state <= S_DIV_LOAD;
        end
        S_DIV_LOAD: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (status.div_done) begin
            if (sel == FLD_V) begin
              state <= S_EMIT;
            end else begin
              sel   <= field_t'(sel + 1'b1);
              state <= S_DIV_LOAD;
            end
          end
        end
        S_EMIT: begin
          if (status.out_free) begin
            if (corner == CORNER_LAST) begin
              state <= S_IDLE;
            end else begin
              corner <= corner + 1'b1;
              state  <= S_POS;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/sprite_quad_vertex_transform_top.sv =====
// ----------------------------------------------------------------------------
// sprite_quad_vertex_transform_top: rotated sprite quad to NDC vertices
// Each draw command yields four corner vertices, rotated about the centre,
// mapped to screen NDC, with texture coordinates scaled by texture size.
//
//   channel   dir  handshake        carries
//   sprite    in   valid / ready    op, dest rect, src rect, rotation, color
//   vertex    out  valid / ready    slot, ndc x/y, tex u/v, color, last
//   cfg       in   cfg_we           cfg_index, cfg_data
//
// A draw runs a lookup and four multiplies, then per corner a position step,
// four divisions on the shared bit-serial divider and an output step. Begin
// and dropped draws are taken in the idle state with none of this work. One
// sprite is in work at a time; the last vertex waits in the output register
// while the next command is taken. A stalled vertex channel holds the
// controller before loading the next corner. Reset is synchronous.
// ----------------------------------------------------------------------------
module sprite_quad_vertex_transform_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [sqvt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sqvt_pkg::CFG_W-1:0]      cfg_data,
  sqvt_sprite_if.sink                     sprite,
  sqvt_vertex_if.source                   vertex
);
  import sqvt_pkg::*;

  sprite_t    in_data;
  vertex_t    out_data;
  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       out_valid;

  // Payload packing
  assign in_data.op       = sprite.op;
  assign in_data.dest_x   = sprite.dest_x;
  assign in_data.dest_y   = sprite.dest_y;
  assign in_data.dest_w   = sprite.dest_w;
  assign in_data.dest_h   = sprite.dest_h;
  assign in_data.src_x    = sprite.src_x;
  assign in_data.src_y    = sprite.src_y;
  assign in_data.src_w    = sprite.src_w;
  assign in_data.src_h    = sprite.src_h;
  assign in_data.rotation = sprite.rotation;
  assign in_data.color    = sprite.color;

  sqvt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sprite.valid),
    .in_op    (sprite.op),
    .in_ready (sprite.ready),
    .status   (status),
    .cmd      (cmd)
  );

  sqvt_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (vertex.ready)
  );

  // Result channel
  assign vertex.valid        = out_valid;
  assign vertex.vertex_slot  = out_data.vertex_slot;
  assign vertex.ndc_x        = out_data.ndc_x;
  assign vertex.ndc_y        = out_data.ndc_y;
  assign vertex.tex_u        = out_data.tex_u;
  assign vertex.tex_v        = out_data.tex_v;
  assign vertex.vertex_color = out_data.vertex_color;
  assign vertex.last         = out_data.last;

  // A vertex is never loaded over one that has not been transferred
  assert property (@(posedge clk) disable iff (rst) cmd.load_out |-> status.out_free)
    else $error("vertex register overwritten");

  // No command is taken while a division is running
  assert property (@(posedge clk) disable iff (rst) status.div_busy |-> !sprite.ready)
    else $error("command accepted during division");

  // The divider is started only when idle
  assert property (@(posedge clk) disable iff (rst) cmd.div_start |-> !status.div_busy)
    else $error("divider restarted while busy");

  // A result is stored only on the cycle after the divider finishes
  assert property (@(posedge clk) disable iff (rst)
    cmd.store_field |-> $past(status.div_busy))
    else $error("quotient stored without a division");

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench for the sprite quad vertex transform
// Sends begin and draw commands over the sprite channel and checks every
// corner vertex against an in-bench fixed-point transform of each sprite.
// A directed table comes first, then random phases under several register
// settings, with bursty input, a stalling vertex sink and one long hold-off.
// ----------------------------------------------------------------------------
module tb;
  import sqvt_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd5;
  localparam int TAB_STEPS = 2 ** SINE_TABLE_BITS;
  localparam int TAB_QTR   = TAB_STEPS / 4;
  localparam int IDLE_WAIT = 400;

  // Directed table row: either a register write or a command
  typedef struct {
    bit                is_cfg;
    logic [CFG_IDX_W-1:0] cfg_sel;
    logic [CFG_W-1:0]  cfg_val;
    sprite_t           cmd;
    bit                known_ndc;
    bit                known_tex;
    int                ndc_x0, ndc_y0, u0, v0, u3, v3;
  } row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  sqvt_sprite_if spr();
  sqvt_vertex_if vtx();

  sprite_quad_vertex_transform_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sprite    (spr),
    .vertex    (vtx)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mirror of the block state
  longint  scr_w, scr_h, tex_w, tex_h, lim_reg, sprite_cnt;
  longint  qsine [0:TAB_QTR];
  vertex_t vertex_q [$];
  int      errors = 0;
  int      hold_req = 0;
  row_t    rows [$];

  // ------------------------------------------------------------------------
  // Fixed-point transform of one sprite
  // ------------------------------------------------------------------------
  function automatic longint fdiv(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Taylor series of sin through x^15, Q1.14
  function automatic longint taylor_sine(longint unsigned r);
    longint unsigned x, x2, term;
    longint          acc, v;
    x = (r * 64'd6746518852 + (64'd1 << (SINE_TABLE_BITS - 1))) >> SINE_TABLE_BITS;
    x2 = (x * x) >> 30;
    term = x;
    acc = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) acc = acc - longint'(term);
      else            acc = acc + longint'(term);
    end
    v = fdiv(acc + 32768, 65536);
    if (v < 0) v = 0;
    if (v > 16384) v = 16384;
    return v;
  endfunction

  function automatic longint wave(int k);
    int qd, r;
    k  = k % TAB_STEPS;
    qd = k / TAB_QTR;
    r  = k % TAB_QTR;
    case (qd)
      0:       return qsine[r];
      1:       return qsine[TAB_QTR - r];
      2:       return -qsine[r];
      default: return -qsine[TAB_QTR - r];
    endcase
  endfunction

  // Queues the four corners a command yields and updates the counter
  function automatic void transform_sprite(sprite_t s, output int n);
    longint  eff, sn, cs, cx, cy, w, h, tw, th, ox, oy, px, py, tx, ty;
    int      k;
    vertex_t vx;
    n = 0;
    if (s.op == OP_BEGIN) begin
      sprite_cnt = 0;
      return;
    end
    eff = lim_reg;
    if (eff > MAX_SPRITES) eff = MAX_SPRITES;
    if (eff > 2047) eff = 2047;
    if (sprite_cnt >= eff) return;
    k  = ((int'(s.rotation) + (1 << (15 - SINE_TABLE_BITS))) >> (16 - SINE_TABLE_BITS))
         % TAB_STEPS;
    sn = wave(k);
    cs = wave(k + TAB_QTR);
    w  = (scr_w == 0) ? 1 : scr_w;
    h  = (scr_h == 0) ? 1 : scr_h;
    tw = (tex_w == 0) ? 1 : tex_w;
    th = (tex_h == 0) ? 1 : tex_h;
    cx = 2 * longint'(s.dest_x) + longint'(s.dest_w);
    cy = 2 * longint'(s.dest_y) + longint'(s.dest_h);
    for (int c = 0; c < 4; c++) begin
      ox = c[0] ? longint'(s.dest_w) : -longint'(s.dest_w);
      oy = c[1] ? longint'(s.dest_h) : -longint'(s.dest_h);
      px = cx * 16384 + cs * ox - sn * oy;
      py = cy * 16384 + sn * ox + cs * oy;
      tx = c[0] ? longint'(s.src_x) + longint'(s.src_w) : longint'(s.src_x);
      ty = c[1] ? longint'(s.src_y) + longint'(s.src_h) : longint'(s.src_y);
      vx.vertex_slot  = SLOT_W'(sprite_cnt * 4 + c);
      vx.ndc_x        = 16'(clip16(fdiv(px + 8 * w, 16 * w) - 16384));
      vx.ndc_y        = 16'(clip16(16384 - fdiv(py + 8 * h, 16 * h)));
      vx.tex_u        = 16'(clip16(fdiv(512 * tx + tw, 2 * tw)));
      vx.tex_v        = 16'(clip16(fdiv(512 * ty + th, 2 * th)));
      vx.vertex_color = s.color;
      vx.last         = (c == 3);
      vertex_q.push_back(vx);
    end
    sprite_cnt = (sprite_cnt + 1) % 2048;
    n = 4;
  endfunction

  // ------------------------------------------------------------------------
  // Register writes, done only while the block is idle
  // ------------------------------------------------------------------------
  task automatic wait_idle();
    while (vertex_q.size() != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] sel, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    case (sel)
      CFG_SCREEN_W:     scr_w   = val;
      CFG_SCREEN_H:     scr_h   = val;
      CFG_TEXTURE_W:    tex_w   = val;
      CFG_TEXTURE_H:    tex_h   = val;
      CFG_SPRITE_LIMIT: lim_reg = val[LIMIT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(int sw, int sh, int tw, int th, int lm);
    wait_idle();
    write_reg(CFG_SCREEN_W, CFG_W'(sw));
    write_reg(CFG_SCREEN_H, CFG_W'(sh));
    write_reg(CFG_TEXTURE_W, CFG_W'(tw));
    write_reg(CFG_TEXTURE_H, CFG_W'(th));
    write_reg(CFG_SPRITE_LIMIT, CFG_W'(lm));
  endtask

  // ------------------------------------------------------------------------
  // Command sender: called at a rising edge, returns at the transfer edge
  // ------------------------------------------------------------------------
  int burst_left = 0;

  task automatic send_cmd(sprite_t s, output int n);
    bit ok;
    spr.valid    <= 1'b1;
    spr.op       <= s.op;
    spr.dest_x   <= s.dest_x;
    spr.dest_y   <= s.dest_y;
    spr.dest_w   <= s.dest_w;
    spr.dest_h   <= s.dest_h;
    spr.src_x    <= s.src_x;
    spr.src_y    <= s.src_y;
    spr.src_w    <= s.src_w;
    spr.src_h    <= s.src_h;
    spr.rotation <= s.rotation;
    spr.color    <= s.color;
    do begin
      @(negedge clk);
      ok = spr.ready;
      @(posedge clk);
    end while (!ok);
    transform_sprite(s, n);
  endtask

  // Bursts of back-to-back transfers separated by random gaps
  task automatic burst_gap();
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 8);
    if ($urandom_range(0, 3) != 0) begin
      spr.valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  endtask

  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return COORD_W'($urandom);
      1: return COORD_W'($urandom_range(0, 4000) - 2000);
      2: case ($urandom_range(0, 3))
           0: return 16'sh8000;
           1: return 16'sh7FFF;
           2: return 16'sh0000;
           default: return 16'shFFFF;
         endcase
      default: return COORD_W'($urandom_range(0, 20000) - 10000);
    endcase
  endfunction

  function automatic sprite_t rand_cmd();
    sprite_t s;
    s.op       = ($urandom_range(0, 9) == 0) ? OP_BEGIN : OP_DRAW;
    s.dest_x   = rand_coord();
    s.dest_y   = rand_coord();
    s.dest_w   = rand_coord();
    s.dest_h   = rand_coord();
    s.src_x    = rand_coord();
    s.src_y    = rand_coord();
    s.src_w    = rand_coord();
    s.src_h    = rand_coord();
    s.rotation = ANGLE_W'($urandom);
    s.color    = $urandom;
    // full-texture source now and then
    if ($urandom_range(0, 4) == 0) begin
      s.src_x = '0;
      s.src_y = '0;
      s.src_w = COORD_W'(tex_w * 16);
      s.src_h = COORD_W'(tex_h * 16);
    end
    return s;
  endfunction

  function automatic sprite_t mk_cmd(logic op, int dx, int dy, int dw, int dh,
                                     int sx, int sy, int sw, int sh,
                                     int rot, logic [31:0] col);
    sprite_t s;
    s.op = op;
    s.dest_x = 16'(dx); s.dest_y = 16'(dy); s.dest_w = 16'(dw); s.dest_h = 16'(dh);
    s.src_x = 16'(sx);  s.src_y = 16'(sy);  s.src_w = 16'(sw);  s.src_h = 16'(sh);
    s.rotation = 16'(rot);
    s.color = col;
    return s;
  endfunction

  function automatic void add_cmd(sprite_t s);
    row_t r;
    r = '{default: 0};
    r.cmd = s;
    rows.push_back(r);
  endfunction

  function automatic void add_reg(logic [CFG_IDX_W-1:0] sel, int val);
    row_t r;
    r = '{default: 0};
    r.is_cfg  = 1'b1;
    r.cfg_sel = sel;
    r.cfg_val = CFG_W'(val);
    rows.push_back(r);
  endfunction

  // ------------------------------------------------------------------------
  // Vertex sink: stall pattern plus one long hold-off on request
  // ------------------------------------------------------------------------
  initial begin
    int hold_cnt;
    int mode;
    int cyc;
    hold_cnt = 0;
    mode = 0;
    cyc = 0;
    vtx.ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_req != 0) begin
        hold_cnt = hold_req;
        hold_req = 0;
      end
      if (cyc % 64 == 0) mode = $urandom_range(0, 3);
      if (hold_cnt > 0) begin
        hold_cnt--;
        vtx.ready <= 1'b0;
      end else begin
        case (mode)
          0:       vtx.ready <= 1'b1;
          1:       vtx.ready <= $urandom_range(0, 1);
          2:       vtx.ready <= (cyc % 5 == 0);
          default: vtx.ready <= ($urandom_range(0, 9) == 0);
        endcase
      end
    end
  end

  // Compare each vertex transfer with the oldest expected corner
  always @(negedge clk) begin
    vertex_t e;
    if (!rst && vtx.valid && vtx.ready) begin
      if (vertex_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected vertex slot %0d", $time, vtx.vertex_slot);
      end else begin
        e = vertex_q.pop_front();
        if (vtx.vertex_slot !== e.vertex_slot) begin
          errors++;
          $display("%0t: vertex_slot exp %0d got %0d", $time, e.vertex_slot, vtx.vertex_slot);
        end
        if (vtx.ndc_x !== e.ndc_x) begin
          errors++;
          $display("%0t: ndc_x exp %0d got %0d", $time, e.ndc_x, vtx.ndc_x);
        end
        if (vtx.ndc_y !== e.ndc_y) begin
          errors++;
          $display("%0t: ndc_y exp %0d got %0d", $time, e.ndc_y, vtx.ndc_y);
        end
        if (vtx.tex_u !== e.tex_u) begin
          errors++;
          $display("%0t: tex_u exp %0d got %0d", $time, e.tex_u, vtx.tex_u);
        end
        if (vtx.tex_v !== e.tex_v) begin
          errors++;
          $display("%0t: tex_v exp %0d got %0d", $time, e.tex_v, vtx.tex_v);
        end
        if (vtx.vertex_color !== e.vertex_color) begin
          errors++;
          $display("%0t: vertex_color exp %h got %h", $time, e.vertex_color,
                   vtx.vertex_color);
        end
        if (vtx.last !== e.last) begin
          errors++;
          $display("%0t: last exp %0b got %0b", $time, e.last, vtx.last);
        end
      end
    end
  end

  // Run limit
  initial begin
    #6000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // ------------------------------------------------------------------------
  // Main sequence
  // ------------------------------------------------------------------------
  initial begin
    int      n;
    int      base;
    sprite_t s;
    row_t    r;

    spr.valid = 1'b0;
    spr.op = OP_BEGIN;
    {spr.dest_x, spr.dest_y, spr.dest_w, spr.dest_h} = '0;
    {spr.src_x, spr.src_y, spr.src_w, spr.src_h} = '0;
    spr.rotation = '0;
    spr.color = '0;

    scr_w = 1280; scr_h = 720; tex_w = 256; tex_h = 256;
    lim_reg = 1024; sprite_cnt = 0;
    for (int i = 0; i <= TAB_QTR; i++) qsine[i] = taylor_sine(i);

    // Directed rows
    add_cmd(mk_cmd(OP_BEGIN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // full-texture draw on a zero-size quad at the origin
    add_cmd(mk_cmd(OP_DRAW, 0, 0, 0, 0, 0, 0, 4096, 4096, 0, 32'hFFFFFFFF));
    rows[$].known_ndc = 1;
    rows[$].known_tex = 1;
    rows[$].ndc_x0 = -16384; rows[$].ndc_y0 = 16384;
    rows[$].u0 = 0; rows[$].v0 = 0; rows[$].u3 = 4096; rows[$].v3 = 4096;
    // source extremes saturate both ways
    add_cmd(mk_cmd(OP_DRAW, 32767, -32768, 32767, -32768,
                   32767, -32768, 32767, -32768, 16'hFFFF, 32'h0));
    rows[$].known_tex = 1;
    rows[$].u0 = 32767; rows[$].v0 = -32768; rows[$].u3 = 32767; rows[$].v3 = -32768;
    add_cmd(mk_cmd(OP_DRAW, -32768, 32767, -32768, 32767, 0, 0, -1, -1, 16'h8000, 32'h12345678));
    add_cmd(mk_cmd(OP_DRAW, 1600, 800, 640, 320, 160, 160, 800, 800, 16'h4000, 32'hA5A5A5A5));
    add_cmd(mk_cmd(OP_DRAW, 1600, 800, 640, 320, 160, 160, 800, 800, 16'hC000, 32'h5A5A5A5A));
    add_cmd(mk_cmd(OP_DRAW, 1600, 800, 640, 320, 160, 160, 800, 800, 16'h0020, 32'hFF00FF00));
    add_cmd(mk_cmd(OP_DRAW, 1600, 800, 640, 320, 160, 160, 800, 800, 16'h2000, 32'h00FF00FF));
    // sprite limit of one drops the second draw
    add_reg(CFG_SPRITE_LIMIT, 1);
    add_cmd(mk_cmd(OP_BEGIN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_cmd(mk_cmd(OP_DRAW, 100, 100, 50, 50, 0, 0, 64, 64, 16'h1000, 32'h11111111));
    add_cmd(mk_cmd(OP_DRAW, 200, 200, 50, 50, 0, 0, 64, 64, 16'h1000, 32'h22222222));
    add_cmd(mk_cmd(OP_BEGIN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_cmd(mk_cmd(OP_DRAW, 300, 300, 50, 50, 0, 0, 64, 64, 16'h1000, 32'h33333333));
    // a limit of zero drops everything; out-of-list index is ignored
    add_reg(CFG_SPRITE_LIMIT, 0);
    add_cmd(mk_cmd(OP_DRAW, 300, 300, 50, 50, 0, 0, 64, 64, 16'h1000, 32'h44444444));
    add_reg(CFG_UNUSED, 8191);
    add_reg(CFG_SPRITE_LIMIT, 2047);
    add_cmd(mk_cmd(OP_DRAW, 300, 300, 50, 50, 0, 0, 64, 64, 16'h1000, 32'h55555555));

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      r = rows[i];
      if (r.is_cfg) begin
        spr.valid <= 1'b0;
        wait_idle();
        write_reg(r.cfg_sel, r.cfg_val);
      end else begin
        send_cmd(r.cmd, n);
        // the new corners sit at the tail of the queue
        base = vertex_q.size() - n;
        if (n == 4) begin
          if (r.known_ndc) begin
            vertex_q[base].ndc_x = 16'(r.ndc_x0);
            vertex_q[base].ndc_y = 16'(r.ndc_y0);
          end
          if (r.known_tex) begin
            vertex_q[base].tex_u   = 16'(r.u0);
            vertex_q[base].tex_v   = 16'(r.v0);
            vertex_q[base+3].tex_u = 16'(r.u3);
            vertex_q[base+3].tex_v = 16'(r.v3);
          end
        end
        burst_gap();
      end
    end

    // Random phases under several register settings
    for (int ph = 0; ph < 4; ph++) begin
      spr.valid <= 1'b0;
      case (ph)
        0: set_regs(1280, 720, 256, 256, 1024);
        1: set_regs(1, 1, 1, 1, 5);
        2: set_regs(8191, 4096, 0, 8191, 2047);
        default: set_regs(0, 480, 4096, 64, 1000);
      endcase
      for (int i = 0; i < 30; i++) begin
        s = rand_cmd();
        send_cmd(s, n);
        // long sink hold-off while commands keep coming
        if (ph == 0 && i == 10) hold_req = 900;
        // sender waits for every expected vertex once
        if (ph == 2 && i == 15) begin
          spr.valid <= 1'b0;
          while (vertex_q.size() != 0) @(posedge clk);
        end else begin
          burst_gap();
        end
      end
    end
    spr.valid <= 1'b0;

    while (vertex_q.size() != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
